/* src/sfws_pkg.sv */
// shared types, constants and the rotate helper for the sha-1 first word search filter
`timescale 1ns / 1ps
package sfws_pkg;

   localparam int SFWS_ROUNDS = 80;
   localparam int SFWS_WORDS  = 16;

   localparam logic [31:0] H0_INIT = 32'h67452301;
   localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
   localparam logic [31:0] H2_INIT = 32'h98BADCFE;
   localparam logic [31:0] H3_INIT = 32'h10325476;
   localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
   localparam logic [31:0] K_R0    = 32'h5A827999;
   localparam logic [31:0] K_R1    = 32'h6ED9EBA1;
   localparam logic [31:0] K_R2    = 32'h8F1BBCDC;
   localparam logic [31:0] K_R3    = 32'hCA62C1D6;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  word_index;
      logic [31:0] data_word;
      logic [31:0] candidate_tag;
   } sfws_req_type;

   typedef struct packed {
      logic        match;
      logic [31:0] result_tag;
   } sfws_rsp_type;

   // entry 0 is the schedule word of the current round
   typedef logic [SFWS_WORDS-1:0][31:0] sfws_window_type;

   typedef struct packed {
      logic            valid;
      logic [31:0]     tag;
      logic [31:0]     a;
      logic [31:0]     b;
      logic [31:0]     c;
      logic [31:0]     d;
      logic [31:0]     e;
      sfws_window_type win;
   } sfws_stage_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
      rotl32 = (v << n) | (v >> (32 - n));
   endfunction

endpackage

/* src/sfws_round.sv */
// one registered sha-1 round with its message schedule step
`timescale 1ns / 1ps
module sfws_round
   import sfws_pkg::*;
#(
   parameter int ROUND = 0
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  sfws_stage_type stage_in,
   output sfws_stage_type stage_out
);

   localparam int GROUP = ROUND / 20;

   logic            valid_ff;
   sfws_stage_type  pay_ff;
   sfws_stage_type  pay_in;
   logic [31:0]     f;
   logic [31:0]     k;
   logic [31:0]     w_next;

   always_comb begin
      case (GROUP)
         0: begin
            f = (stage_in.b & stage_in.c) | (~stage_in.b & stage_in.d);
            k = K_R0;
         end
         1: begin
            f = stage_in.b ^ stage_in.c ^ stage_in.d;
            k = K_R1;
         end
         2: begin
            f = (stage_in.b & stage_in.c) | (stage_in.b & stage_in.d) |
                (stage_in.c & stage_in.d);
            k = K_R2;
         end
         default: begin
            f = stage_in.b ^ stage_in.c ^ stage_in.d;
            k = K_R3;
         end
      endcase
   end

   // w[t+16] from the window that starts at w[t]
   assign w_next = rotl32(stage_in.win[13] ^ stage_in.win[8] ^ stage_in.win[2] ^
                          stage_in.win[0], 1);

   always_comb begin
      pay_in       = stage_in;
      pay_in.a     = rotl32(stage_in.a, 5) + f + stage_in.e + stage_in.win[0] + k;
      pay_in.b     = stage_in.a;
      pay_in.c     = rotl32(stage_in.b, 30);
      pay_in.d     = stage_in.c;
      pay_in.e     = stage_in.d;
      pay_in.win   = {w_next, stage_in.win[SFWS_WORDS-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pay_ff <= pay_in;
      end
   end

   always_comb begin
      stage_out       = pay_ff;
      stage_out.valid = valid_ff;
   end

endmodule

/* src/sha1_first_word_search_filter.sv */
// top level of the sha-1 first word search filter
`timescale 1ns / 1ps
// usage:
// req_ carries one beat per item: a load (cmd 0) writes fixed message word
// word_index (1..15, 0 is ignored) at once and gives no result; a test
// (cmd 1) hashes data_word as message word 0 with the stored words 1..15.
// each test gives one rsp_ beat: match is set when the first digest word
// equals the target loaded through csr_we / csr_wdata, result_tag echoes the tag.
// the hash is fully unrolled: an input register, 80 round registers and an
// output register, through which each test beat passes on its way to rsp_.
// a new beat is taken every cycle unless the pipeline is held; throughput is one
// test per clock, set by the one-round-per-stage pipeline.
// a test takes a copy of the stored words when accepted, so later loads do
// not touch tests in flight.
// while rsp_valid is high and rsp_stall is asserted the whole pipeline holds
// and req_stall is raised; nothing is lost or repeated.
// reset clears all valid bits and the target; stored words are undefined
// until loaded.
module sha1_first_word_search_filter
   import sfws_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  sfws_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output sfws_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   logic [31:0]    target_ff;
   logic [31:0]    fixed_ff [SFWS_WORDS-1];
   logic           advance;
   logic           in_valid_ff;
   sfws_stage_type in_pay_ff;
   sfws_stage_type in_pay_in;
   sfws_stage_type pipe [SFWS_ROUNDS+1];
   logic           rsp_valid_ff;
   sfws_rsp_type   rsp_ff;
   logic           req_accept;
   logic [3:0]     load_addr;

   assign advance    = !(rsp_valid_ff && rsp_stall);
   assign req_stall  = !advance;
   assign req_accept = req_valid && advance;
   assign load_addr  = req_data.word_index - 4'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_we) begin
         target_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && req_data.cmd == CMD_LOAD && req_data.word_index != 4'd0) begin
         fixed_ff[load_addr] <= req_data.data_word;
      end
   end

   always_comb begin
      in_pay_in        = '0;
      in_pay_in.tag    = req_data.candidate_tag;
      in_pay_in.a      = H0_INIT;
      in_pay_in.b      = H1_INIT;
      in_pay_in.c      = H2_INIT;
      in_pay_in.d      = H3_INIT;
      in_pay_in.e      = H4_INIT;
      in_pay_in.win[0] = req_data.data_word;
      for (int i = 1; i < SFWS_WORDS; i++) begin
         in_pay_in.win[i] = fixed_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff <= req_valid && req_data.cmd == CMD_TEST;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_pay_ff <= in_pay_in;
      end
   end

   always_comb begin
      pipe[0]       = in_pay_ff;
      pipe[0].valid = in_valid_ff;
   end

   for (genvar r = 0; r < SFWS_ROUNDS; r++) begin : g_round
      sfws_round #(
         .ROUND(r)
      ) u_round (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .stage_in (pipe[r]),
         .stage_out(pipe[r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= pipe[SFWS_ROUNDS].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff.match      <= (pipe[SFWS_ROUNDS].a + H0_INIT) == target_ff;
         rsp_ff.result_tag <= pipe[SFWS_ROUNDS].tag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // no result beat straight after reset
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // a load beat is stored where its index points
   a_load_store: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_data.cmd == CMD_LOAD && req_data.word_index != 4'd0 |=>
      fixed_ff[$past(load_addr)] == $past(req_data.data_word))
      else $error("fixed word not stored");

   // a held pipeline keeps its first round stage
   a_hold_stage: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(pipe[1].valid) && $stable(pipe[1].tag))
      else $error("round stage moved during stall");

endmodule

/* verif/tb_sha1_first_word_search_filter.sv */
// self-checking testbench for the sha-1 first word search filter
`timescale 1ns / 1ps
module tb_sha1_first_word_search_filter;
   import sfws_pkg::*;

   localparam int PIPE_DEPTH  = 82;
   localparam int CYCLE_LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   sfws_req_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   sfws_rsp_type rsp_data;
   logic         csr_we;
   logic [31:0]  csr_wdata;

   // predictor state
   bit [31:0]    msg_words [1:15];
   bit [31:0]    target_word;
   sfws_rsp_type pending_rsp [$];
   sfws_req_type directed_rows [$];

   int           mismatches;
   int           cycle_count;
   int           burst_left;

   sha1_first_word_search_filter uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic bit [31:0] lead_digest_word(bit [31:0] w0);
      bit [31:0] sched [16];
      bit [31:0] a, b, c, d, e, f, k, wt, x, sum;
      a = H0_INIT; b = H1_INIT; c = H2_INIT; d = H3_INIT; e = H4_INIT;
      sched[0] = w0;
      for (int t = 1; t < 16; t++) sched[t] = msg_words[t];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) begin
            wt = sched[t];
         end else begin
            x = sched[(t - 3) & 15] ^ sched[(t - 8) & 15] ^ sched[(t - 14) & 15]
                ^ sched[t & 15];
            wt = {x[30:0], x[31]};
            sched[t & 15] = wt;
         end
         if (t < 20) begin
            f = (b & c) | (~b & d);
            k = K_R0;
         end else if (t < 40) begin
            f = b ^ c ^ d;
            k = K_R1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d);
            k = K_R2;
         end else begin
            f = b ^ c ^ d;
            k = K_R3;
         end
         sum = {a[26:0], a[31:27]} + f + e + wt + k;
         e = d;
         d = c;
         c = {b[1:0], b[31:2]};
         b = a;
         a = sum;
      end
      return a + H0_INIT;
   endfunction

   // update the predictor with one accepted request beat
   function automatic void absorb_request(sfws_req_type r);
      sfws_rsp_type rsp;
      if (r.cmd == CMD_LOAD) begin
         // index zero is dropped by the block
         if (r.word_index != 4'd0) msg_words[r.word_index] = r.data_word;
      end else begin
         rsp.match      = (lead_digest_word(r.data_word) == target_word);
         rsp.result_tag = r.candidate_tag;
         pending_rsp.push_back(rsp);
      end
   endfunction

   function automatic sfws_req_type make_req(logic cmd, logic [3:0] idx,
                                             logic [31:0] data, logic [31:0] tag);
      sfws_req_type r;
      r.cmd           = cmd;
      r.word_index    = idx;
      r.data_word     = data;
      r.candidate_tag = tag;
      return r;
   endfunction

   task automatic send_beat(sfws_req_type r);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      absorb_request(r);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(0, 20);
      end
   endtask

   // write the target only with the pipeline drained
   task automatic set_target(bit [31:0] value);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (PIPE_DEPTH + 8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      target_word = value;
   endtask

   // receiver: the stall pattern rotates through four stretches, one of which never stalls
   always @(posedge clock) begin
      case ((cycle_count / 512) % 4)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 9) < 3);
         2: rsp_stall <= (cycle_count % 3 == 0);
         default: rsp_stall <= ($urandom_range(0, 9) < 7);
      endcase
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // result beat checker
   always @(posedge clock) begin
      sfws_rsp_type exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: match %0b tag %h",
                        rsp_data.match, rsp_data.result_tag);
         end else begin
            exp_rsp = pending_rsp.pop_front();
            if (rsp_data.match !== exp_rsp.match ||
                rsp_data.result_tag !== exp_rsp.result_tag) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result mismatch: expected match %0b tag %h, got match %0b tag %h",
                           exp_rsp.match, exp_rsp.result_tag,
                           rsp_data.match, rsp_data.result_tag);
            end
         end
      end
   end

   initial begin
      bit [31:0] fav_word;
      bit [31:0] data;
      int        pick;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      mismatches  = 0;
      cycle_count = 0;
      burst_left  = 0;
      target_word = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: fill every fixed word first, extremes of each field
      directed_rows.push_back(make_req(CMD_LOAD, 4'd1,  32'h00000000, 32'h0));
      directed_rows.push_back(make_req(CMD_LOAD, 4'd2,  32'hFFFFFFFF, 32'h0));
      directed_rows.push_back(make_req(CMD_LOAD, 4'd3,  32'hAAAAAAAA, 32'hFFFFFFFF));
      directed_rows.push_back(make_req(CMD_LOAD, 4'd4,  32'h55555555, 32'h0));
      for (int i = 5; i <= 14; i++)
         directed_rows.push_back(make_req(CMD_LOAD, i[3:0], $urandom, $urandom));
      directed_rows.push_back(make_req(CMD_LOAD, 4'd15, 32'h80000000, 32'h0));
      // index zero is ignored, no result
      directed_rows.push_back(make_req(CMD_LOAD, 4'd0,  32'hDEADBEEF, 32'h0));
      directed_rows.push_back(make_req(CMD_TEST, 4'd0,  32'h00000000, 32'h00000000));
      directed_rows.push_back(make_req(CMD_TEST, 4'd15, 32'hFFFFFFFF, 32'hFFFFFFFF));
      directed_rows.push_back(make_req(CMD_TEST, 4'd7,  32'h80000000, 32'h00000001));
      directed_rows.push_back(make_req(CMD_TEST, 4'd0,  32'h00000001, 32'h80000000));
      directed_rows.push_back(make_req(CMD_LOAD, 4'd15, 32'hFFFFFFFF, 32'h0));
      directed_rows.push_back(make_req(CMD_TEST, 4'd0,  32'h00000000, 32'h12345678));

      set_target(32'h00000000);
      foreach (directed_rows[i]) send_beat(directed_rows[i]);

      // a target that the next candidate hits
      set_target(lead_digest_word(32'h00000000));
      send_beat(make_req(CMD_TEST, 4'd0, 32'h00000000, 32'hA5A5A5A5));
      send_beat(make_req(CMD_TEST, 4'd0, 32'h00000001, 32'h5A5A5A5A));

      // random phases, each under its own target
      for (int phase = 0; phase < 5; phase++) begin
         fav_word = $urandom;
         case (phase)
            0: set_target(32'hFFFFFFFF);
            1: set_target(lead_digest_word(fav_word));
            2: set_target($urandom);
            3: set_target(32'h00000000);
            default: set_target(lead_digest_word(fav_word));
         endcase
         for (int n = 0; n < 100; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < ((phase == 1 || phase == 4) ? 4 : 25)) begin
               data = $urandom;
               send_beat(make_req(CMD_LOAD, 4'($urandom_range(0, 15)), data, $urandom));
            end else begin
               data = (pick >= 85) ? fav_word : $urandom;
               send_beat(make_req(CMD_TEST, 4'($urandom_range(0, 15)), data, $urandom));
            end
         end
      end

      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (PIPE_DEPTH + 20) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* files.f */
src/sfws_pkg.sv
src/sfws_round.sv
src/sha1_first_word_search_filter.sv
verif/tb_sha1_first_word_search_filter.sv
